FILE: hdl/positive_clip_fir_shaper_macros.svh
// ----------------------------------------------------------------------------
// positive_clip_fir_shaper_macros.svh
// assertion macros for the shaper, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef POSITIVE_CLIP_FIR_SHAPER_MACROS_SVH
`define POSITIVE_CLIP_FIR_SHAPER_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define PFS_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define PFS_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PFS_ASSERT_IMP(label, clk, rstn, ante, cons, msg)
`define PFS_ASSERT_NXT(label, clk, rstn, ante, cons, msg)
`endif

`endif

FILE: hdl/pfs_pkg.sv
// ----------------------------------------------------------------------------
// pfs_pkg
// shared widths, codes, states and control structs of the pulse shaper
// ----------------------------------------------------------------------------
package pfs_pkg;

    // field widths
    localparam int REQ_W     = 1;
    localparam int IDX_IN_W  = 6;
    localparam int COEF_W    = 18;
    localparam int SAMP_W    = 16;
    localparam int HIST_W    = 15;
    localparam int TAPCFG_W  = 7;
    localparam int OUT_W     = 16;
    localparam int FRAC_W    = 14;
    localparam int PROD_W    = COEF_W + HIST_W + 1;

    // request codes
    localparam logic [REQ_W-1:0] REQ_SAMPLE = 1'b0;
    localparam logic [REQ_W-1:0] REQ_COEF   = 1'b1;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN,
        ST_DONE
    } state_t;

    // controls from the sequencer to the multiply-accumulate unit
    typedef struct packed {
        logic clear;
        logic data_v;
    } mac_ctl_t;

    // history read request
    typedef struct packed {
        logic en;
        logic live;
    } hist_rd_t;

endpackage

FILE: hdl/pfs_intf.sv
// ----------------------------------------------------------------------------
// pfs_intf
// valid/ready channels of the shaper: input items, results, tap count writes
// ----------------------------------------------------------------------------
interface pfs_item_if;
    logic                                    valid;
    logic                                    ready;
    logic [pfs_pkg::REQ_W-1:0]               req_type;
    logic [pfs_pkg::IDX_IN_W-1:0]            coef_index;
    logic signed [pfs_pkg::COEF_W-1:0]       coef_value;
    logic signed [pfs_pkg::SAMP_W-1:0]       sample;
    logic                                    first_sample;

    modport source (output valid, req_type, coef_index, coef_value, sample, first_sample,
                    input ready);
    modport sink   (input valid, req_type, coef_index, coef_value, sample, first_sample,
                    output ready);
endinterface

interface pfs_result_if;
    logic                                    valid;
    logic                                    ready;
    logic signed [pfs_pkg::OUT_W-1:0]        shaped_sample;
    logic                                    saturated;

    modport source (output valid, shaped_sample, saturated, input ready);
    modport sink   (input valid, shaped_sample, saturated, output ready);
endinterface

interface pfs_cfg_if;
    logic                                    valid;
    logic                                    ready;
    logic [pfs_pkg::TAPCFG_W-1:0]            tap_count;

    modport source (output valid, tap_count, input ready);
    modport sink   (input valid, tap_count, output ready);
endinterface

FILE: hdl/positive_clip_fir_shaper.sv
// ----------------------------------------------------------------------------
// positive_clip_fir_shaper
// causal fir pulse shaper over positive samples with loadable taps
// ----------------------------------------------------------------------------
//  channel   dir   payload                                            handshake
//  item      in    req_type coef_index coef_value sample first_sample valid/ready
//  result    out   shaped_sample saturated                            valid/ready
//  cfg       in    tap_count                                          valid/ready
//
//  a coefficient write completes in idle; a sample goes through issue, drain
//  and done to its result (straight to drain when N is 0), N = min(tap_count,
//  MAX_TAPS), with one multiply-accumulate per tap
//  the next item is taken as soon as the sequencer is back in idle, even while
//  the result register still holds an untaken result; a stalled result only
//  holds the block in its last step. reset clears taps and history at once.
// ----------------------------------------------------------------------------
`include "positive_clip_fir_shaper_macros.svh"

module positive_clip_fir_shaper #(
    parameter int MAX_TAPS = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    pfs_item_if.sink      item,
    pfs_result_if.source  result,
    pfs_cfg_if.sink       cfg
);

    localparam int IDX_W = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int CNT_W = $clog2(MAX_TAPS + 1);
    localparam int ACC_W = pfs_pkg::PROD_W + $clog2(MAX_TAPS);

    pfs_pkg::state_t                    state_reg, state_next;
    logic [CNT_W-1:0]                   k_reg, k_next;
    logic [CNT_W-1:0]                   act_reg, act_next;
    logic [CNT_W-1:0]                   fill_reg, fill_next;
    logic [IDX_W-1:0]                   head_reg, head_next;
    logic [IDX_W-1:0]                   rd_ptr_reg, rd_ptr_next;
    logic [pfs_pkg::TAPCFG_W-1:0]       tap_count_reg;
    logic                               data_v_reg;
    logic                               res_valid_reg, res_valid_next;
    logic signed [pfs_pkg::OUT_W-1:0]   res_sample_reg;
    logic                               res_sat_reg;

    logic                               item_acc;
    logic [CNT_W-1:0]                   act_full;
    logic [CNT_W-1:0]                   k_inc;
    logic [IDX_W-1:0]                   head_wrap;
    logic                               issue;
    logic                               hist_we;
    logic [pfs_pkg::HIST_W-1:0]         hist_wdata;
    logic                               coef_we;
    logic                               res_load;
    pfs_pkg::mac_ctl_t                  mac_ctl;
    pfs_pkg::hist_rd_t                  hist_rd;
    logic signed [pfs_pkg::COEF_W-1:0]  coef_data;
    logic [pfs_pkg::HIST_W-1:0]         samp_data;
    logic                               mac_busy;
    logic signed [pfs_pkg::OUT_W-1:0]   mac_q;
    logic                               mac_sat;

    // handshakes
    assign item.ready = (state_reg == pfs_pkg::ST_IDLE);
    assign item_acc   = item.valid && item.ready;
    assign cfg.ready  = 1'b1;

    // active taps and pointer helpers
    assign act_full   = (32'(tap_count_reg) > MAX_TAPS) ? CNT_W'(MAX_TAPS)
                                                        : CNT_W'(tap_count_reg);
    assign k_inc      = k_reg + CNT_W'(1);
    assign head_wrap  = (head_reg == IDX_W'(MAX_TAPS - 1)) ? '0 : head_reg + IDX_W'(1);
    assign hist_wdata = (item.sample > 16'sd0) ? item.sample[pfs_pkg::HIST_W-1:0] : '0;

    // tap count register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_count_reg <= pfs_pkg::TAPCFG_W'(64);
        end
        else if (cfg.valid && cfg.ready)
        begin
            tap_count_reg <= cfg.tap_count;
        end
    end

    // sequencer and pointer registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pfs_pkg::ST_IDLE;
            k_reg         <= '0;
            act_reg       <= '0;
            fill_reg      <= '0;
            head_reg      <= '0;
            rd_ptr_reg    <= '0;
            data_v_reg    <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            act_reg       <= act_next;
            fill_reg      <= fill_next;
            head_reg      <= head_next;
            rd_ptr_reg    <= rd_ptr_next;
            data_v_reg    <= issue;
            res_valid_reg <= res_valid_next;
        end
    end

    // result payload register
    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            res_sample_reg <= mac_q;
            res_sat_reg    <= mac_sat;
        end
    end

    // next state and controls
    always_comb
    begin
        state_next  = state_reg;
        k_next      = k_reg;
        act_next    = act_reg;
        fill_next   = fill_reg;
        head_next   = head_reg;
        rd_ptr_next = rd_ptr_reg;
        issue       = 1'b0;
        hist_we     = 1'b0;
        coef_we     = 1'b0;
        res_load    = 1'b0;
        mac_ctl     = '0;
        case (state_reg)
            pfs_pkg::ST_IDLE:
            begin
                if (item_acc)
                begin
                    if (item.req_type == pfs_pkg::REQ_COEF)
                    begin
                        coef_we = (32'(item.coef_index) < MAX_TAPS);
                    end
                    else
                    begin
                        hist_we       = 1'b1;
                        head_next     = head_wrap;
                        rd_ptr_next   = head_wrap;
                        act_next      = act_full;
                        k_next        = '0;
                        mac_ctl.clear = 1'b1;
                        if (item.first_sample)
                        begin
                            fill_next = CNT_W'(1);
                        end
                        else if (fill_reg != CNT_W'(MAX_TAPS))
                        begin
                            fill_next = fill_reg + CNT_W'(1);
                        end
                        state_next = (act_full == '0) ? pfs_pkg::ST_DRAIN
                                                      : pfs_pkg::ST_ISSUE;
                    end
                end
            end
            pfs_pkg::ST_ISSUE:
            begin
                issue       = 1'b1;
                k_next      = k_inc;
                rd_ptr_next = (rd_ptr_reg == '0) ? IDX_W'(MAX_TAPS - 1)
                                                 : rd_ptr_reg - IDX_W'(1);
                if (k_inc == act_reg)
                begin
                    state_next = pfs_pkg::ST_DRAIN;
                end
            end
            pfs_pkg::ST_DRAIN:
            begin
                if (!data_v_reg && !mac_busy)
                begin
                    state_next = pfs_pkg::ST_DONE;
                end
            end
            pfs_pkg::ST_DONE:
            begin
                if (!res_valid_reg || result.ready)
                begin
                    res_load   = 1'b1;
                    state_next = pfs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pfs_pkg::ST_IDLE;
            end
        endcase
        mac_ctl.data_v = data_v_reg;
    end

    // result valid: set on load, dropped when the transaction completes
    always_comb
    begin
        if (res_load)
        begin
            res_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    assign result.valid         = res_valid_reg;
    assign result.shaped_sample = res_sample_reg;
    assign result.saturated     = res_sat_reg;

    // history read request
    assign hist_rd.en   = issue;
    assign hist_rd.live = (k_reg < fill_reg);

    pfs_coef_mem #(
        .MAX_TAPS (MAX_TAPS),
        .IDX_W    (IDX_W)
    ) u_coef (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (coef_we),
        .waddr (IDX_W'(32'(item.coef_index))),
        .wdata (item.coef_value),
        .re    (issue),
        .raddr (k_reg[IDX_W-1:0]),
        .rdata (coef_data)
    );

    pfs_hist_mem #(
        .MAX_TAPS (MAX_TAPS),
        .IDX_W    (IDX_W)
    ) u_hist (
        .clk   (clk),
        .we    (hist_we),
        .waddr (head_wrap),
        .wdata (hist_wdata),
        .rd    (hist_rd),
        .raddr (rd_ptr_reg),
        .rdata (samp_data)
    );

    pfs_mac #(
        .ACC_W (ACC_W)
    ) u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mac_ctl),
        .coef  (coef_data),
        .samp  (samp_data),
        .busy  (mac_busy),
        .q     (mac_q),
        .sat   (mac_sat)
    );

    // checks
    `PFS_ASSERT_NXT(a_sample_starts, clk, rst_n, item.valid && item.ready && item.req_type == pfs_pkg::REQ_SAMPLE, state_reg == pfs_pkg::ST_ISSUE || state_reg == pfs_pkg::ST_DRAIN, "sample did not start the tap sweep")
    `PFS_ASSERT_IMP(a_tap_in_range, clk, rst_n, state_reg == pfs_pkg::ST_ISSUE, k_reg < act_reg, "tap index beyond active count")
    `PFS_ASSERT_IMP(a_read_from_issue, clk, rst_n, data_v_reg, $past(state_reg == pfs_pkg::ST_ISSUE), "read data without an issue")
    `PFS_ASSERT_IMP(a_result_from_done, clk, rst_n, $rose(result.valid), $past(state_reg == pfs_pkg::ST_DONE), "result raised outside the final step")

endmodule

FILE: hdl/pfs_coef_mem.sv
// ----------------------------------------------------------------------------
// pfs_coef_mem
// tap weight memory with per-entry valid bits, unwritten taps read as zero
// ----------------------------------------------------------------------------
module pfs_coef_mem #(
    parameter int MAX_TAPS = 64,
    parameter int IDX_W    = 6
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              we,
    input  logic [IDX_W-1:0]                  waddr,
    input  logic signed [pfs_pkg::COEF_W-1:0] wdata,
    input  logic                              re,
    input  logic [IDX_W-1:0]                  raddr,
    output logic signed [pfs_pkg::COEF_W-1:0] rdata
);

    logic signed [pfs_pkg::COEF_W-1:0] mem [MAX_TAPS];
    logic [MAX_TAPS-1:0]               valid_reg;
    logic signed [pfs_pkg::COEF_W-1:0] rdata_reg;

    // valid bits, cleared by reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (we)
        begin
            valid_reg[waddr] <= 1'b1;
        end
    end

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= valid_reg[raddr] ? mem[raddr] : '0;
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/pfs_hist_mem.sv
// ----------------------------------------------------------------------------
// pfs_hist_mem
// circular sample history, entries older than the fill count read as zero
// ----------------------------------------------------------------------------
module pfs_hist_mem #(
    parameter int MAX_TAPS = 64,
    parameter int IDX_W    = 6
) (
    input  logic                          clk,
    input  logic                          we,
    input  logic [IDX_W-1:0]              waddr,
    input  logic [pfs_pkg::HIST_W-1:0]    wdata,
    input  pfs_pkg::hist_rd_t             rd,
    input  logic [IDX_W-1:0]              raddr,
    output logic [pfs_pkg::HIST_W-1:0]    rdata
);

    logic [pfs_pkg::HIST_W-1:0] mem [MAX_TAPS];
    logic [pfs_pkg::HIST_W-1:0] rdata_reg;

    // write port and registered read port, stale entries masked
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (rd.en)
        begin
            rdata_reg <= rd.live ? mem[raddr] : '0;
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/pfs_mac.sv
// ----------------------------------------------------------------------------
// pfs_mac
// shared multiply-accumulate unit with truncating scale and 16-bit clip
// ----------------------------------------------------------------------------
module pfs_mac #(
    parameter int ACC_W = 40
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  pfs_pkg::mac_ctl_t                 ctl,
    input  logic signed [pfs_pkg::COEF_W-1:0] coef,
    input  logic [pfs_pkg::HIST_W-1:0]        samp,
    output logic                              busy,
    output logic signed [pfs_pkg::OUT_W-1:0]  q,
    output logic                              sat
);

    localparam logic signed [ACC_W-1:0] ROUND_ADJ = ACC_W'((1 << pfs_pkg::FRAC_W) - 1);
    localparam logic signed [ACC_W-1:0] Q_HI      = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0] Q_LO      = ACC_W'(-32768);

    logic signed [pfs_pkg::PROD_W-1:0] prod_reg;
    logic                              prod_v_reg;
    logic signed [ACC_W-1:0]           acc_reg;
    logic signed [ACC_W-1:0]           acc_adj;
    logic signed [ACC_W-1:0]           q_wide;

    // product valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_v_reg <= 1'b0;
        end
        else
        begin
            prod_v_reg <= ctl.data_v;
        end
    end

    // multiply stage then accumulate stage
    always_ff @(posedge clk)
    begin
        if (ctl.data_v)
        begin
            prod_reg <= pfs_pkg::PROD_W'(coef) * pfs_pkg::PROD_W'($signed({1'b0, samp}));
        end
        if (ctl.clear)
        begin
            acc_reg <= '0;
        end
        else if (prod_v_reg)
        begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
    end

    // divide by 2^14 toward zero, then clip
    always_comb
    begin
        acc_adj = acc_reg[ACC_W-1] ? acc_reg + ROUND_ADJ : acc_reg;
        q_wide  = acc_adj >>> pfs_pkg::FRAC_W;
        if (q_wide > Q_HI)
        begin
            q   = 16'sh7fff;
            sat = 1'b1;
        end
        else if (q_wide < Q_LO)
        begin
            q   = 16'sh8000;
            sat = 1'b1;
        end
        else
        begin
            q   = q_wide[pfs_pkg::OUT_W-1:0];
            sat = 1'b0;
        end
    end

    assign busy = prod_v_reg;

endmodule
